// ===== rtl/core/qesm_pkg.sv =====
// Shared types, widths and constants of the quadrature encoder speed meter.
package qesm_pkg;

  // Time counter width (valid range 16..64).
  localparam int TIME_BITS = 32;

  localparam int LPT_W      = 8;
  localparam int SCALE_W    = 20;
  localparam int TIMEOUT_W  = 16;
  localparam int PERIOD_W   = 8;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  localparam int SPEED_W    = 21;
  localparam int TICK_W     = 32;
  localparam int DIVISOR_W  = LPT_W + SCALE_W;
  localparam int DIV_CNT_W  = $clog2(SCALE_W);
  localparam int CMP_W      = TIME_BITS + SCALE_W;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_TURN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 2'd3;

  // Register reset values.
  localparam logic [LPT_W-1:0]     RST_LINES_PER_TURN = 8'd24;
  localparam logic [SCALE_W-1:0]   RST_SPEED_SCALE    = 20'd100000;
  localparam logic [TIMEOUT_W-1:0] RST_STOP_TIMEOUT   = 16'd100;
  localparam logic [PERIOD_W-1:0]  RST_SAMPLE_PERIOD  = 8'd3;

  // Both lines toggled in one sample.
  localparam logic [1:0] CHG_BOTH = 2'b11;
  localparam logic [1:0] CHG_NONE = 2'b00;

  typedef struct packed {
    logic [LPT_W-1:0]     lines_per_turn;
    logic [SCALE_W-1:0]   speed_scale;
    logic [TIMEOUT_W-1:0] stop_timeout_ms;
    logic [PERIOD_W-1:0]  sample_period_ms;
  } qesm_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } qesm_div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_EMIT
  } qesm_state_t;

endpackage

// ===== rtl/core/qesm_if.sv =====
// Valid/ready channel interfaces for encoder samples and speed results.
interface qesm_in_if;
  logic valid;
  logic ready;
  logic line_a;
  logic line_b;
  modport source (output valid, output line_a, output line_b, input ready);
  modport sink   (input valid, input line_a, input line_b, output ready);
endinterface

interface qesm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [qesm_pkg::SPEED_W-1:0] speed;
  logic                              overspeed;
  logic [qesm_pkg::TICK_W-1:0]       tick_count;
  modport source (output valid, output speed, output overspeed, output tick_count,
                  input ready);
  modport sink   (input valid, input speed, input overspeed, input tick_count,
                  output ready);
endinterface

// ===== rtl/core/qesm_cfg.sv =====
// Configuration register file of the speed meter.
module qesm_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                we,
  input  logic [qesm_pkg::CFG_IDX_W-1:0]      idx,
  input  logic [qesm_pkg::CFG_DATA_W-1:0]     wdata,
  output qesm_pkg::qesm_cfg_t                 cfg
);

  qesm_pkg::qesm_cfg_t cfg_r;
  qesm_pkg::qesm_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (idx)
        qesm_pkg::CFG_LINES_PER_TURN:
          cfg_nxt.lines_per_turn = wdata[qesm_pkg::LPT_W-1:0];
        qesm_pkg::CFG_SPEED_SCALE:
          cfg_nxt.speed_scale = wdata[qesm_pkg::SCALE_W-1:0];
        qesm_pkg::CFG_STOP_TIMEOUT:
          cfg_nxt.stop_timeout_ms = wdata[qesm_pkg::TIMEOUT_W-1:0];
        qesm_pkg::CFG_SAMPLE_PERIOD:
          cfg_nxt.sample_period_ms = wdata[qesm_pkg::PERIOD_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lines_per_turn   <= qesm_pkg::RST_LINES_PER_TURN;
      cfg_r.speed_scale      <= qesm_pkg::RST_SPEED_SCALE;
      cfg_r.stop_timeout_ms  <= qesm_pkg::RST_STOP_TIMEOUT;
      cfg_r.sample_period_ms <= qesm_pkg::RST_SAMPLE_PERIOD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/qesm_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module qesm_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [qesm_pkg::SCALE_W-1:0]        dividend,
  input  logic [qesm_pkg::DIVISOR_W-1:0]      divisor,
  output logic [qesm_pkg::SCALE_W-1:0]        quotient,
  output qesm_pkg::qesm_div_stat_t            stat
);

  logic [qesm_pkg::SCALE_W-1:0]   num_r, num_nxt;
  logic [qesm_pkg::DIVISOR_W-1:0] dvs_r, dvs_nxt;
  logic [qesm_pkg::DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [qesm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;

  logic [qesm_pkg::DIVISOR_W:0]   trial;
  logic [qesm_pkg::DIVISOR_W:0]   diff;
  logic                           ge;

  always_comb begin
    trial = {rem_r, num_r[qesm_pkg::SCALE_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    num_nxt  = num_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = qesm_pkg::DIV_CNT_W'(qesm_pkg::SCALE_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift the next dividend bit in, subtract when it fits
      rem_nxt = ge ? diff[qesm_pkg::DIVISOR_W-1:0] : trial[qesm_pkg::DIVISOR_W-1:0];
      num_nxt = {num_r[qesm_pkg::SCALE_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quotient  = num_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/core/quadrature_encoder_speed_meter_unit.sv =====
// Top level of the quadrature encoder speed meter: sequencer, state and output register.
// A single-line change within the scale passes through the evaluate, multiply, start
// and divide states, the divide run by the serial divider (one quotient bit per cycle);
// every other sample goes from evaluate straight to emit. One sample is in work at a
// time: no new sample is taken until the last is emitted, and emit waits on the sink.
// Reset (rst_n, synchronous, active low) loads register defaults and clears the control and tracking state.
module quadrature_encoder_speed_meter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  qesm_in_if.sink                         in_ch,
  qesm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [qesm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [qesm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TB = qesm_pkg::TIME_BITS;
  localparam int SW = qesm_pkg::SCALE_W;

  qesm_pkg::qesm_cfg_t      cfg;
  qesm_pkg::qesm_div_stat_t div_stat;
  logic [SW-1:0]            div_q;

  qesm_pkg::qesm_state_t state_r, state_nxt;

  // Encoder tracking state
  logic [1:0]                          last_lines_r, last_lines_nxt;
  logic [TB-1:0]                       last_chg_r, last_chg_nxt;
  logic [TB-1:0]                       time_now_r, time_now_nxt;
  logic [qesm_pkg::TICK_W-1:0]         edge_r, edge_nxt;
  logic signed [qesm_pkg::SPEED_W-1:0] speed_r, speed_nxt;
  logic                                ovs_r, ovs_nxt;

  // Per-sample working registers
  logic [1:0]                          lines_r, lines_nxt;
  logic [TB-1:0]                       now_r, now_nxt;
  logic                                rev_r, rev_nxt;
  logic [SW-1:0]                       dlt_r, dlt_nxt;
  logic [qesm_pkg::DIVISOR_W-1:0]      divisor_r, divisor_nxt;

  // Output register
  logic                                out_valid_r, out_valid_nxt;
  logic signed [qesm_pkg::SPEED_W-1:0] out_speed_r, out_speed_nxt;
  logic                                out_ovs_r, out_ovs_nxt;
  logic [qesm_pkg::TICK_W-1:0]         out_tick_r, out_tick_nxt;

  // Control outputs of the sequencer
  logic in_ready;
  logic div_start;
  logic out_load;

  // Evaluation terms
  logic [TB-1:0]                  delta;
  logic [qesm_pkg::CMP_W-1:0]     delta_ext;
  logic [qesm_pkg::CMP_W-1:0]     scale_ext;
  logic [qesm_pkg::CMP_W-1:0]     timeout_ext;
  logic [1:0]                     changed;
  logic                           same_time;
  logic                           reverse;
  logic [qesm_pkg::LPT_W-1:0]     res;
  logic [qesm_pkg::DIVISOR_W-1:0] product;

  qesm_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_idx),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  qesm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cfg.speed_scale),
    .divisor  (divisor_r),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // Elapsed time wraps with the counter; compares run in a width that holds both sides.
  always_comb begin
    delta       = now_r - last_chg_r;
    delta_ext   = {{SW{1'b0}}, delta};
    scale_ext   = {{TB{1'b0}}, cfg.speed_scale};
    timeout_ext = qesm_pkg::CMP_W'(cfg.stop_timeout_ms);
    changed     = lines_r ^ last_lines_r;
    same_time   = (now_r == last_chg_r);
    // reverse direction on 0->1, 1->3, 3->2, 2->0 (lines coded A + 2*B)
    reverse     = ((last_lines_r == 2'd0) && (lines_r == 2'd1)) ||
                  ((last_lines_r == 2'd1) && (lines_r == 2'd3)) ||
                  ((last_lines_r == 2'd3) && (lines_r == 2'd2)) ||
                  ((last_lines_r == 2'd2) && (lines_r == 2'd0));
    // a resolution of zero counts as one
    res         = (cfg.lines_per_turn == '0) ? qesm_pkg::LPT_W'(1) : cfg.lines_per_turn;
    product     = qesm_pkg::DIVISOR_W'(res) * qesm_pkg::DIVISOR_W'(dlt_r);
  end

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qesm_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = qesm_pkg::ST_EVAL;
      end
      qesm_pkg::ST_EVAL: begin
        if (!same_time && (changed != qesm_pkg::CHG_NONE) &&
            (changed != qesm_pkg::CHG_BOTH) && (delta_ext <= scale_ext)) begin
          state_nxt = qesm_pkg::ST_MUL;
        end else begin
          state_nxt = qesm_pkg::ST_EMIT;
        end
      end
      qesm_pkg::ST_MUL:   state_nxt = qesm_pkg::ST_START;
      qesm_pkg::ST_START: state_nxt = qesm_pkg::ST_DIV;
      qesm_pkg::ST_DIV: begin
        if (div_stat.done) state_nxt = qesm_pkg::ST_EMIT;
      end
      qesm_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) state_nxt = qesm_pkg::ST_IDLE;
      end
      default: state_nxt = qesm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      qesm_pkg::ST_IDLE:  in_ready  = 1'b1;
      qesm_pkg::ST_START: div_start = 1'b1;
      qesm_pkg::ST_EMIT:  out_load  = !out_valid_r || out_ch.ready;
      default: begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
      end
    endcase
  end

  // Datapath
  always_comb begin
    last_lines_nxt = last_lines_r;
    last_chg_nxt   = last_chg_r;
    time_now_nxt   = time_now_r;
    edge_nxt       = edge_r;
    speed_nxt      = speed_r;
    ovs_nxt        = ovs_r;
    lines_nxt      = lines_r;
    now_nxt        = now_r;
    rev_nxt        = rev_r;
    dlt_nxt        = dlt_r;
    divisor_nxt    = divisor_r;
    out_valid_nxt  = out_valid_r;
    out_speed_nxt  = out_speed_r;
    out_ovs_nxt    = out_ovs_r;
    out_tick_nxt   = out_tick_r;

    // drop the result once the sink takes the transaction
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    // capture the sample and its timestamp; advance the clock on every sample
    if (in_ready && in_ch.valid) begin
      lines_nxt    = {in_ch.line_b, in_ch.line_a};
      now_nxt      = time_now_r;
      time_now_nxt = time_now_r + TB'(cfg.sample_period_ms);
    end

    if (state_r == qesm_pkg::ST_EVAL && !same_time) begin
      if (changed == qesm_pkg::CHG_BOTH) begin
        ovs_nxt        = 1'b1;
        edge_nxt       = edge_r + qesm_pkg::TICK_W'(2);
        speed_nxt      = '0;
        last_lines_nxt = lines_r;
        last_chg_nxt   = now_r;
      end else if (changed != qesm_pkg::CHG_NONE) begin
        ovs_nxt        = 1'b0;
        edge_nxt       = edge_r + qesm_pkg::TICK_W'(1);
        rev_nxt        = reverse;
        dlt_nxt        = delta_ext[SW-1:0];
        last_lines_nxt = lines_r;
        last_chg_nxt   = now_r;
        // an elapsed time beyond the scale gives a zero quotient
        if (delta_ext > scale_ext) speed_nxt = '0;
      end else if (delta_ext > timeout_ext) begin
        ovs_nxt      = 1'b0;
        speed_nxt    = '0;
        last_chg_nxt = now_r;
      end
    end

    if (state_r == qesm_pkg::ST_MUL) divisor_nxt = product;

    if (state_r == qesm_pkg::ST_DIV && div_stat.done) begin
      speed_nxt = rev_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_speed_nxt = speed_r;
      out_ovs_nxt   = ovs_r;
      out_tick_nxt  = edge_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= qesm_pkg::ST_IDLE;
      last_lines_r <= '0;
      last_chg_r   <= '0;
      time_now_r   <= '0;
      edge_r       <= '0;
      speed_r      <= '0;
      ovs_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_lines_r <= last_lines_nxt;
      last_chg_r   <= last_chg_nxt;
      time_now_r   <= time_now_nxt;
      edge_r       <= edge_nxt;
      speed_r      <= speed_nxt;
      ovs_r        <= ovs_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lines_r     <= lines_nxt;
    now_r       <= now_nxt;
    rev_r       <= rev_nxt;
    dlt_r       <= dlt_nxt;
    divisor_r   <= divisor_nxt;
    out_speed_r <= out_speed_nxt;
    out_ovs_r   <= out_ovs_nxt;
    out_tick_r  <= out_tick_nxt;
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.speed      = out_speed_r;
  assign out_ch.overspeed  = out_ovs_r;
  assign out_ch.tick_count = out_tick_r;

  // The divider runs only while the sequencer waits on it.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qesm_pkg::ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  // A completed division is seen only in the divide state.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == qesm_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  // An accepted sample moves straight to evaluation.
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == qesm_pkg::ST_EVAL))
    else $error("accepted transaction not evaluated");

  // Overspeed always comes with a zero speed.
  a_ovs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovs_r) |-> (out_speed_r == '0))
    else $error("overspeed result with nonzero speed");

endmodule

// ===== tb/quadrature_encoder_speed_meter_unit_tb.sv =====
// Self-checking testbench for the quadrature encoder speed meter: directed table plus random runs.
module quadrature_encoder_speed_meter_unit_tb;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  // Generous cap: many times the run time of roughly 920 samples.
  localparam int LIMIT_CYCLES  = 600000;
  // Longest path through the block is the divide; allow a margin on top.
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS   = 150;
  localparam int NUM_PHASES    = 6;
  localparam int NUM_DIR       = 24;
  localparam int MAX_GAP       = 20;

  // One expected or observed result transaction.
  typedef struct packed {
    logic [qesm_pkg::SPEED_W-1:0] speed;
    logic                         overspeed;
    logic [qesm_pkg::TICK_W-1:0]  tick_count;
  } speed_rec_t;

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  // One line of the directed table: either a sample or a full register set.
  typedef struct packed {
    row_kind_t           kind;
    logic [1:0]          lines;   // {B, A}
    logic                typed;   // use the hand-written result instead of the predictor
    speed_rec_t          want;
    qesm_pkg::qesm_cfg_t cfg;
  } dir_row_t;

  localparam qesm_pkg::qesm_cfg_t CFG_RESET = '{qesm_pkg::RST_LINES_PER_TURN,
                                                qesm_pkg::RST_SPEED_SCALE,
                                                qesm_pkg::RST_STOP_TIMEOUT,
                                                qesm_pkg::RST_SAMPLE_PERIOD};
  localparam qesm_pkg::qesm_cfg_t NO_CFG    = '0;
  localparam speed_rec_t          NO_REC    = '0;

  // Directed stimulus. Time starts at zero and advances by the sample period after
  // every sample, so the elapsed time per edge below is set by the period in force.
  dir_row_t dir_tab [NUM_DIR] = '{
    // first sample after reset: its time equals the last change time, so ignore it
    '{ROW_SAMPLE, 2'b00, 1'b1, '{21'd0, 1'b0, 32'd0}, NO_CFG},
    // both lines toggle: two ticks, overspeed, speed forced to zero
    '{ROW_SAMPLE, 2'b11, 1'b1, '{21'd0, 1'b1, 32'd2}, NO_CFG},
    '{ROW_SAMPLE, 2'b10, 1'b0, NO_REC, NO_CFG},   // 3->2, reverse
    '{ROW_SAMPLE, 2'b00, 1'b0, NO_REC, NO_CFG},   // 2->0, reverse
    '{ROW_SAMPLE, 2'b10, 1'b0, NO_REC, NO_CFG},   // 0->2, forward
    // zero stop timeout: the next held sample must stop the meter
    '{ROW_CONFIG, 2'b00, 1'b0, NO_REC, '{8'd24, 20'd100000, 16'd0, 8'd3}},
    '{ROW_SAMPLE, 2'b10, 1'b0, NO_REC, NO_CFG},
    // zero resolution is taken as one
    '{ROW_CONFIG, 2'b00, 1'b0, NO_REC, '{8'd0, 20'd100000, 16'd0, 8'd3}},
    '{ROW_SAMPLE, 2'b11, 1'b0, NO_REC, NO_CFG},
    // top scale, unit resolution, 1 ms period: full-range speed both ways
    '{ROW_CONFIG, 2'b00, 1'b0, NO_REC, '{8'd1, 20'd1000000, 16'd100, 8'd1}},
    '{ROW_SAMPLE, 2'b01, 1'b0, NO_REC, NO_CFG},
    '{ROW_SAMPLE, 2'b00, 1'b1, '{21'd1000000, 1'b0, 32'd8}, NO_CFG},
    '{ROW_SAMPLE, 2'b01, 1'b1, '{-21'sd1000000, 1'b0, 32'd9}, NO_CFG},
    // scale of one: any elapsed time beyond 1 ms gives a zero quotient
    '{ROW_CONFIG, 2'b00, 1'b0, NO_REC, '{8'd1, 20'd1, 16'd100, 8'd1}},
    '{ROW_SAMPLE, 2'b11, 1'b0, NO_REC, NO_CFG},
    '{ROW_SAMPLE, 2'b11, 1'b0, NO_REC, NO_CFG},
    '{ROW_SAMPLE, 2'b10, 1'b0, NO_REC, NO_CFG},
    // upper extremes of every register but the scale, which stays at 1000000
    '{ROW_CONFIG, 2'b00, 1'b0, NO_REC, '{8'd255, 20'd1000000, 16'd65535, 8'd255}},
    '{ROW_SAMPLE, 2'b10, 1'b0, NO_REC, NO_CFG},
    '{ROW_SAMPLE, 2'b00, 1'b0, NO_REC, NO_CFG},
    // zero period: one more change lands, then time freezes and samples are ignored
    '{ROW_CONFIG, 2'b00, 1'b0, NO_REC, '{8'd255, 20'd1000000, 16'd65535, 8'd0}},
    '{ROW_SAMPLE, 2'b01, 1'b0, NO_REC, NO_CFG},
    '{ROW_SAMPLE, 2'b11, 1'b0, NO_REC, NO_CFG},
    '{ROW_SAMPLE, 2'b10, 1'b0, NO_REC, NO_CFG}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [qesm_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [qesm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  qesm_in_if  in_if ();
  qesm_out_if out_if ();

  quadrature_encoder_speed_meter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Idle rates in percent per cycle; the main sequence changes them per phase.
  int sender_gap_pct = 19;
  int sink_stall_pct = 47;
  int errors         = 0;

  // Results the meter still owes, oldest first.
  speed_rec_t pending_q [$];

  // Shadow of the meter: its registers and its state.
  qesm_pkg::qesm_cfg_t            m_cfg;
  logic [1:0]                     m_lines;
  logic [qesm_pkg::TIME_BITS-1:0] m_last_edge_t;
  logic [qesm_pkg::TIME_BITS-1:0] m_now;
  logic [qesm_pkg::TICK_W-1:0]    m_ticks;
  logic [qesm_pkg::SPEED_W-1:0]   m_speed;
  logic                           m_ovs;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Advance the shadow by one sample and return the result it should produce.
  function automatic speed_rec_t predict_speed_sample(input logic [1:0] lines);
    logic [qesm_pkg::TIME_BITS-1:0] elapsed;
    logic [1:0]                     toggled;
    logic [63:0]                    divisor;
    logic [63:0]                    quot;
    logic                           backward;
    elapsed  = m_now - m_last_edge_t;   // wraps with the time counter
    toggled  = lines ^ m_lines;
    // reverse direction is the sequence 0-1-3-2-0
    backward = (m_lines == 2'b00 && lines == 2'b01) || (m_lines == 2'b01 && lines == 2'b11) ||
               (m_lines == 2'b11 && lines == 2'b10) || (m_lines == 2'b10 && lines == 2'b00);
    if (m_now != m_last_edge_t) begin
      if (toggled == qesm_pkg::CHG_BOTH) begin
        m_ovs         = 1'b1;
        m_ticks       = m_ticks + 2;
        m_speed       = '0;
        m_lines       = lines;
        m_last_edge_t = m_now;
      end else if (toggled != qesm_pkg::CHG_NONE) begin
        divisor = 64'((m_cfg.lines_per_turn == 8'd0) ? 8'd1 : m_cfg.lines_per_turn) *
                  64'(elapsed);
        if (64'(elapsed) <= 64'(m_cfg.speed_scale)) begin
          quot = 64'(m_cfg.speed_scale) / divisor;
        end else begin
          quot = '0;
        end
        m_ovs         = 1'b0;
        m_ticks       = m_ticks + 1;
        m_speed       = backward ? -quot[qesm_pkg::SPEED_W-1:0] : quot[qesm_pkg::SPEED_W-1:0];
        m_lines       = lines;
        m_last_edge_t = m_now;
      end else if (64'(elapsed) > 64'(m_cfg.stop_timeout_ms)) begin
        // stopped: keep the tick count, drop speed and overspeed
        m_ovs         = 1'b0;
        m_speed       = '0;
        m_last_edge_t = m_now;
      end
    end
    m_now = m_now + qesm_pkg::TIME_BITS'(m_cfg.sample_period_ms);
    return '{m_speed, m_ovs, m_ticks};
  endfunction

  // Offer one sample after a random gap; record its expected result on acceptance.
  // Called and left at a rising edge, with valid still high for the accepted sample.
  task automatic send_sample(input logic [1:0] lines, input logic typed,
                             input speed_rec_t want);
    speed_rec_t predicted;
    int         gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < sender_gap_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.line_a <= lines[0];
    in_if.line_b <= lines[1];
    // look at ready mid-cycle, where nothing is changing; the transaction
    // completes at the next rising edge
    @(negedge clk);
    while (in_if.ready !== 1'b1) @(negedge clk);
    predicted = predict_speed_sample(lines);
    pending_q.push_back(typed ? want : predicted);
    @(posedge clk);
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic settle_results();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    // let the sequencer fall back to idle before any register write
    repeat (2) @(posedge clk);
  endtask

  // Write all four registers on consecutive edges, then mirror them in the shadow.
  task automatic load_config(input qesm_pkg::qesm_cfg_t c);
    cfg_we    <= 1'b1;
    cfg_idx   <= qesm_pkg::CFG_LINES_PER_TURN;
    cfg_wdata <= qesm_pkg::CFG_DATA_W'(c.lines_per_turn);
    @(posedge clk);
    cfg_idx   <= qesm_pkg::CFG_SPEED_SCALE;
    cfg_wdata <= qesm_pkg::CFG_DATA_W'(c.speed_scale);
    @(posedge clk);
    cfg_idx   <= qesm_pkg::CFG_STOP_TIMEOUT;
    cfg_wdata <= qesm_pkg::CFG_DATA_W'(c.stop_timeout_ms);
    @(posedge clk);
    cfg_idx   <= qesm_pkg::CFG_SAMPLE_PERIOD;
    cfg_wdata <= qesm_pkg::CFG_DATA_W'(c.sample_period_ms);
    @(posedge clk);
    cfg_we    <= 1'b0;
    m_cfg = c;
  endtask

  // Receiver: stall at random at the rate of the current phase.
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Result checker: a transaction seen mid-cycle completes at the next rising edge.
  always @(negedge clk) begin : result_check
    speed_rec_t exp_rec;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: speed %0d overspeed %0b ticks %0d",
                 $time, $signed(out_if.speed), out_if.overspeed, out_if.tick_count);
      end else begin
        exp_rec = pending_q.pop_front();
        if (out_if.speed !== exp_rec.speed) begin
          errors++;
          $display("%0t: speed mismatch: expected %0d, got %0d",
                   $time, $signed(exp_rec.speed), $signed(out_if.speed));
        end
        if (out_if.overspeed !== exp_rec.overspeed) begin
          errors++;
          $display("%0t: overspeed mismatch: expected %0b, got %0b",
                   $time, exp_rec.overspeed, out_if.overspeed);
        end
        if (out_if.tick_count !== exp_rec.tick_count) begin
          errors++;
          $display("%0t: tick_count mismatch: expected %0d, got %0d",
                   $time, exp_rec.tick_count, out_if.tick_count);
        end
      end
    end
  end

  // Main sequence: reset, directed table, then six random phases.
  initial begin
    qesm_pkg::qesm_cfg_t cfg;
    logic [1:0]          lines_now;
    logic                rev_dir;
    int                  hold_left;
    int                  r;

    // drive every block input to a known value from the first instant
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.line_a = 1'b0;
    in_if.line_b = 1'b0;

    m_cfg         = CFG_RESET;
    m_lines       = '0;
    m_last_edge_t = '0;
    m_now         = '0;
    m_ticks       = '0;
    m_speed       = '0;
    m_ovs         = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: walk the table, settling before each register set.
    for (int k = 0; k < NUM_DIR; k++) begin
      if (dir_tab[k].kind == ROW_CONFIG) begin
        settle_results();
        load_config(dir_tab[k].cfg);
      end else begin
        send_sample(dir_tab[k].lines, dir_tab[k].typed, dir_tab[k].want);
      end
    end

    // Random part. Most samples follow a proper quadrature sequence with random
    // direction changes and holds of random length (long holds reach the stop
    // timeout); the rest are double toggles and arbitrary jumps.
    lines_now = dir_tab[NUM_DIR-1].lines;
    rev_dir   = 1'b0;
    hold_left = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: cfg = '{8'd1, 20'd1000000, 16'd0, 8'd1};
        2: cfg = '{8'd255, 20'd1, 16'd65535, 8'd255};
        5: cfg = CFG_RESET;
        default: begin
          cfg.lines_per_turn   = ($urandom_range(0, 9) == 0) ? 8'd0 :
                                 8'($urandom_range(1, 255));
          cfg.speed_scale      = 20'($urandom_range(1, 1000000));
          cfg.stop_timeout_ms  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
                                 16'($urandom_range(0, 40));
          cfg.sample_period_ms = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) :
                                 8'($urandom_range(1, 8));
        end
      endcase
      // receiver stalls more in the first two phases, sender idles more in the next two,
      // and neither in the last two
      sender_gap_pct = (p < 2) ? 19 : (p < 4) ? 47 : 0;
      sink_stall_pct = (p < 2) ? 47 : (p < 4) ? 19 : 0;
      settle_results();
      load_config(cfg);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (hold_left > 0) begin
          hold_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 50) begin
            if ($urandom_range(0, 9) == 0) rev_dir = ~rev_dir;
            if (rev_dir) begin
              case (lines_now)
                2'b00:   lines_now = 2'b01;
                2'b01:   lines_now = 2'b11;
                2'b11:   lines_now = 2'b10;
                default: lines_now = 2'b00;
              endcase
            end else begin
              case (lines_now)
                2'b00:   lines_now = 2'b10;
                2'b10:   lines_now = 2'b11;
                2'b11:   lines_now = 2'b01;
                default: lines_now = 2'b00;
              endcase
            end
          end else if (r < 75) begin
            hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
                        $urandom_range(0, 4);
          end else if (r < 88) begin
            lines_now = lines_now ^ qesm_pkg::CHG_BOTH;
          end else begin
            lines_now = 2'($urandom_range(0, 3));
          end
        end
        // hold the sender off once per phase until the meter has caught up
        if (i == PHASE_ITEMS / 2) settle_results();
        send_sample(lines_now, 1'b0, NO_REC);
      end
    end

    settle_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("%0t: timeout with %0d results outstanding", $time, pending_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/qesm_pkg.sv
rtl/core/qesm_if.sv
rtl/core/qesm_cfg.sv
rtl/core/qesm_div.sv
rtl/core/quadrature_encoder_speed_meter_unit.sv
tb/quadrature_encoder_speed_meter_unit_tb.sv
